>>> hdl/pjt_pkg.sv
// ----------------------------------------------------------------------------
// Periodic job timer package
// Request and result types, mode codes and register indexes shared by the
// timer's modules.
// ----------------------------------------------------------------------------
package pjt_pkg;

  localparam int unsigned DataWidth   = 32;
  localparam int unsigned CountWidth  = DataWidth + 1;      // countdown width
  localparam int unsigned CfgIdxWidth = 2;

  // Request modes
  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_OUTCOME = 2'd1,
    MODE_START   = 2'd2,
    MODE_STOP    = 2'd3
  } mode_e;

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CFG_START_DELAY = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_PERIOD      = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_MAX_PERIOD  = 2'd2;

  // Register reset values
  localparam logic [DataWidth-1:0] START_DELAY_RST = '0;
  localparam logic [DataWidth-1:0] PERIOD_RST      = DataWidth'(1);
  localparam logic [DataWidth-1:0] MAX_PERIOD_RST  = DataWidth'(1);

  typedef struct packed {
    mode_e                mode;
    logic                 success;
    logic [DataWidth-1:0] extra_delay;
  } in_item_t;

  typedef struct packed {
    logic                 fire;
    logic                 armed;
    logic                 busy_res;
    logic [DataWidth-1:0] backoff_level;
    logic [DataWidth-1:0] skips_left;
  } out_item_t;

  typedef struct packed {
    logic [DataWidth-1:0] start_delay;
    logic [DataWidth-1:0] period;
    logic [DataWidth-1:0] max_period;
  } cfg_t;

endpackage

>>> hdl/pjt_core.sv
// ----------------------------------------------------------------------------
// Periodic job timer core
// Timer state registers and the single-pass update for one request.
// ----------------------------------------------------------------------------
module pjt_core import pjt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  req_i,
  input  cfg_t      cfg_i,
  output out_item_t rsp_o
);

  logic                  armed_q, armed_d;
  logic                  busy_q, busy_d;
  logic [CountWidth-1:0] remain_q, remain_d;
  logic [DataWidth-1:0]  backoff_q, backoff_d;
  logic [DataWidth-1:0]  skip_q, skip_d;
  logic                  fire;

  // Candidate backoff after a failure: 1 from zero, else doubled (one-hot)
  logic [DataWidth:0]     next_bo;
  logic [2*DataWidth:0]   product;
  logic                   below_cap;

  assign next_bo = (backoff_q == '0) ? (DataWidth+1)'(1) : {backoff_q, 1'b0};

  // next_bo is one-hot, so the exact product is a selected shift of period
  always_comb begin
    product = '0;
    for (int i = 0; i <= DataWidth; i++) begin
      if (next_bo[i]) begin
        product = product | ({(DataWidth+1)'(0), cfg_i.period} << i);
      end
    end
  end

  assign below_cap = (product[2*DataWidth:DataWidth] == '0) &&
                     (product[DataWidth-1:0] < cfg_i.max_period);

  always_comb begin
    armed_d   = armed_q;
    busy_d    = busy_q;
    remain_d  = remain_q;
    backoff_d = backoff_q;
    skip_d    = skip_q;
    fire      = 1'b0;
    case (req_i.mode)
      MODE_TICK: begin
        if (armed_q) begin
          if (remain_q <= CountWidth'(1)) begin
            remain_d = {1'b0, cfg_i.period};
            if (!busy_q) begin
              if (skip_q != '0) begin
                skip_d = skip_q - DataWidth'(1);
              end else begin
                busy_d = 1'b1;
                fire   = 1'b1;
              end
            end
          end else begin
            remain_d = remain_q - CountWidth'(1);
          end
        end
      end
      MODE_OUTCOME: begin
        if (busy_q) begin
          busy_d = 1'b0;
          if (req_i.success) begin
            backoff_d = '0;
          end else begin
            if (below_cap) backoff_d = next_bo[DataWidth-1:0];
            skip_d = below_cap ? next_bo[DataWidth-1:0] : backoff_q;
          end
        end
      end
      MODE_START: begin
        armed_d  = 1'b1;
        remain_d = {1'b0, cfg_i.start_delay} + {1'b0, req_i.extra_delay};
      end
      default: begin
        armed_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q   <= 1'b0;
      busy_q    <= 1'b0;
      remain_q  <= '0;
      backoff_q <= '0;
      skip_q    <= '0;
    end else if (step_i) begin
      armed_q   <= armed_d;
      busy_q    <= busy_d;
      remain_q  <= remain_d;
      backoff_q <= backoff_d;
      skip_q    <= skip_d;
    end
  end

  assign rsp_o = '{fire:          fire,
                   armed:         armed_d,
                   busy_res:      busy_d,
                   backoff_level: backoff_d,
                   skips_left:    skip_d};

endmodule

>>> hdl/periodic_job_timer_with_backoff.sv
// ----------------------------------------------------------------------------
// Periodic job timer with binary exponential backoff
// Arms on start, counts down on ticks, fires the job on expiry unless an
// attempt is outstanding or skips are pending; failures grow the backoff.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   --------------------   -----------------------------------------
//  in        in_valid_i/in_ready_o  in_req_i   (mode, success, extra_delay)
//  out       out_valid_o/out_ready_i out_rsp_o (fire, armed, busy_res,
//                                              backoff_level, skips_left)
//  cfg       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  One request per cycle unless a full result register is not taken. A
//  request waits in the input register; the state update and result are
//  computed in one pass by pjt_core and the result lands in the output register.
//  Reset clears the timer state and loads start_delay 0, period 1,
//  max_period 1; the block takes requests right after reset.
//  When the result register is full and not taken, hold the input register
//  and the timer state; ready falls only while both stages are full.
//
module periodic_job_timer_with_backoff import pjt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // request channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_item_t               in_req_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_item_t              out_rsp_o,
  // configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [DataWidth-1:0]   cfg_data_i
);

  // Configuration registers
  cfg_t cfg_q;

  // Input stage
  logic     in_valid_q;
  in_item_t in_req_q;

  // Result stage
  logic      out_valid_q;
  out_item_t out_rsp_q;
  out_item_t core_rsp;

  // Advance the input stage into the result stage when the result slot
  // is empty or being drained this cycle.
  logic step;
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  // Configuration is always accepted; writes must only arrive while idle, which the block itself does not enforce.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{start_delay: START_DELAY_RST,
                 period:      PERIOD_RST,
                 max_period:  MAX_PERIOD_RST};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_START_DELAY: cfg_q.start_delay <= cfg_data_i;
        CFG_PERIOD:      cfg_q.period      <= cfg_data_i;
        CFG_MAX_PERIOD:  cfg_q.max_period  <= cfg_data_i;
        default: ;      // drop writes to unknown indexes
      endcase
    end
  end

  // Input register: capture a new request whenever the slot frees up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_req_q <= in_req_i;
    end
  end

  pjt_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (in_req_q),
    .cfg_i  (cfg_q),
    .rsp_o  (core_rsp)
  );

  // Result register: load on advance, clear when taken with nothing behind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_rsp_q <= core_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef NO_ASSERTIONS
  // Backoff only ever holds zero or a power of two
  a_backoff_pow2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(out_rsp_o.backoff_level))
    else $error("backoff level is not zero or a power of two");

  // A fired job is armed and marked busy in the same result
  a_fire_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.fire) |-> (out_rsp_o.busy_res && out_rsp_o.armed))
    else $error("fire without armed and busy");

  // A stalled result with a waiting request must not lose the request
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && in_valid_q) |=> in_valid_q)
    else $error("request dropped while result stalled");
`endif

endmodule
